// ----- design/hcc_pkg.sv -----
package hcc_pkg;

  localparam int COORD_W          = 16;
  localparam int INDEX_W          = 32;
  localparam int ORDER_W          = 5;
  localparam int LEVEL_IDX_W      = 4;
  localparam int INDEX_POS_W      = 5;
  localparam int LEVELS           = 16;
  localparam int LEVELS_PER_STAGE = 4;
  localparam int STAGES           = LEVELS / LEVELS_PER_STAGE;

  localparam logic [ORDER_W-1:0] MIN_ORDER   = 5'd1;
  localparam logic [ORDER_W-1:0] MAX_ORDER   = 5'd16;
  localparam logic [ORDER_W-1:0] RESET_ORDER = 5'd16;

  typedef enum logic {
    ACT_TO_INDEX  = 1'b0,
    ACT_TO_COORDS = 1'b1
  } hcc_action_t;

  // One item in flight. The x, y and d fields are rewritten in place, one
  // level at a time, from the top level downwards. The sw and inv flags hold
  // the orientation of the sub-square that the walk has reached.
  typedef struct packed {
    hcc_action_t        act;
    logic               sw;
    logic               inv;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] d;
  } hcc_item_t;

  typedef struct packed {
    logic       xb;
    logic       yb;
    logic [1:0] q;
    logic       sw;
    logic       inv;
  } hcc_level_t;

  // One level of the walk in either direction. The orientation is a swap
  // followed by a complement of both bits; the two operations commute, so
  // the same mapping serves both ways.
  function automatic hcc_level_t hcc_level(hcc_action_t act, logic sw, logic inv,
                                           logic xb, logic yb, logic [1:0] q);
    logic       a;
    logic       b;
    logic       rx;
    logic       ry;
    logic       ex;
    logic       ey;
    hcc_level_t r;
    a = sw ? yb : xb;
    b = sw ? xb : yb;
    if (act == ACT_TO_INDEX) begin
      rx = a ^ inv;
      ry = b ^ inv;
    end else begin
      rx = q[1];
      ry = q[0] ^ q[1];
    end
    ex = rx ^ inv;
    ey = ry ^ inv;
    if (act == ACT_TO_INDEX) begin
      r.xb = xb;
      r.yb = yb;
    end else begin
      r.xb = sw ? ey : ex;
      r.yb = sw ? ex : ey;
    end
    r.q   = {rx, rx ^ ry};
    r.sw  = ry ? sw : ~sw;
    r.inv = (!ry && rx) ? ~inv : inv;
    return r;
  endfunction

  // Bit j is set when j lies below the curve order.
  function automatic logic [COORD_W-1:0] coord_mask(logic [ORDER_W-1:0] m);
    logic [COORD_W-1:0] mask;
    for (int j = 0; j < COORD_W; j++) begin
      mask[j] = ORDER_W'(j) < m;
    end
    return mask;
  endfunction

endpackage

// ----- design/hilbert_curve_converter.sv -----
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_action, in_x_coord, in_y_coord, in_curve_index
// out      out_valid/ out_stall out_x_out, out_y_out, out_index_out
// cfg      cfg_wr_en            cfg_wr_data (curve order)
//
// One item is accepted per cycle while in_stall is low; a result passes through
// one register stage per four bit levels of the curve.
// Reset empties the pipeline and sets the curve order to 16.
// A stage holds its item only while it is full and the stage after it stalls,
// so bubbles are squeezed out and in_stall follows out_stall combinationally.
module hilbert_curve_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hcc_pkg::ORDER_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [hcc_pkg::COORD_W-1:0] in_x_coord,
  input  logic [hcc_pkg::COORD_W-1:0] in_y_coord,
  input  logic [hcc_pkg::INDEX_W-1:0] in_curve_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hcc_pkg::COORD_W-1:0] out_x_out,
  output logic [hcc_pkg::COORD_W-1:0] out_y_out,
  output logic [hcc_pkg::INDEX_W-1:0] out_index_out
);
  import hcc_pkg::*;

  logic [ORDER_W-1:0] order_r;
  logic [ORDER_W-1:0] order_eff;
  logic [COORD_W-1:0] cmask;
  hcc_item_t          in_item;

  logic      st_valid [0:STAGES];
  logic      st_stall [0:STAGES];
  hcc_item_t st_item  [0:STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= RESET_ORDER;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (order_r < MIN_ORDER) begin
      order_eff = MIN_ORDER;
    end else if (order_r > MAX_ORDER) begin
      order_eff = MAX_ORDER;
    end else begin
      order_eff = order_r;
    end
  end

  assign cmask = coord_mask(order_eff);

  // The pipeline always walks all sixteen levels. Each empty level above the
  // order swaps the axes, so an odd order starts with the axes swapped to
  // cancel that out.
  always_comb begin
    in_item     = '0;
    in_item.act = hcc_action_t'(in_action);
    in_item.sw  = order_eff[0];
    in_item.inv = 1'b0;
    if (in_item.act == ACT_TO_INDEX) begin
      in_item.x = in_x_coord & cmask;
      in_item.y = in_y_coord & cmask;
    end else begin
      for (int j = 0; j < COORD_W; j++) begin
        in_item.d[2*j +: 2] = in_curve_index[2*j +: 2] & {2{cmask[j]}};
      end
    end
  end

  assign st_valid[0] = in_valid;
  assign st_item[0]  = in_item;
  assign in_stall    = st_stall[0];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    hcc_stage #(
      .TOP_LEVEL(LEVELS - 1 - i * LEVELS_PER_STAGE)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(st_valid[i]),
      .stall_o(st_stall[i]),
      .item_i (st_item[i]),
      .valid_o(st_valid[i+1]),
      .stall_i(st_stall[i+1]),
      .item_o (st_item[i+1])
    );
  end

  assign st_stall[STAGES] = out_stall;
  assign out_valid        = st_valid[STAGES];

  always_comb begin
    out_x_out     = '0;
    out_y_out     = '0;
    out_index_out = '0;
    if (st_item[STAGES].act == ACT_TO_COORDS) begin
      out_x_out = st_item[STAGES].x;
      out_y_out = st_item[STAGES].y;
    end else begin
      out_index_out = st_item[STAGES].d;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled while the output side was free");

  a_order_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    order_eff >= MIN_ORDER && order_eff <= MAX_ORDER)
    else $error("effective curve order out of range");

  a_index_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && st_item[STAGES].act == ACT_TO_INDEX |->
      out_x_out == '0 && out_y_out == '0)
    else $error("coordinate fields not zero on an index result");
`endif

endmodule

// ----- design/hcc_stage.sv -----
module hcc_stage #(
  parameter int TOP_LEVEL = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              stall_o,
  input  hcc_pkg::hcc_item_t item_i,
  output logic              valid_o,
  input  logic              stall_i,
  output hcc_pkg::hcc_item_t item_o
);
  import hcc_pkg::*;

  logic       valid_r;
  hcc_item_t  item_r;
  hcc_item_t  item_nxt;

  // Four dependent levels on single bits; each level only sees one bit of
  // x and y and two bits of d.
  always_comb begin
    hcc_item_t  cur;
    hcc_level_t lr;
    cur = item_i;
    for (int j = 0; j < LEVELS_PER_STAGE; j++) begin
      lr = hcc_level(cur.act, cur.sw, cur.inv,
                     cur.x[LEVEL_IDX_W'(TOP_LEVEL - j)],
                     cur.y[LEVEL_IDX_W'(TOP_LEVEL - j)],
                     cur.d[INDEX_POS_W'(2 * (TOP_LEVEL - j)) +: 2]);
      cur.x[LEVEL_IDX_W'(TOP_LEVEL - j)] = lr.xb;
      cur.y[LEVEL_IDX_W'(TOP_LEVEL - j)] = lr.yb;
      cur.d[INDEX_POS_W'(2 * (TOP_LEVEL - j)) +: 2] = lr.q;
      cur.sw  = lr.sw;
      cur.inv = lr.inv;
    end
    item_nxt = cur;
  end

  assign stall_o = valid_r && stall_i;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o && valid_i) begin
      item_r <= item_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && stall_i |=> valid_r && $stable(item_r))
    else $error("stage lost or changed a stalled item");

  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_i && !stall_i |=> !valid_r)
    else $error("stage invented an item");

  a_load_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && !stall_o |=> valid_r && item_r == $past(item_nxt))
    else $error("stage did not capture an accepted item");
`endif

endmodule

// ----- tb/hcc_checker.sv -----
module hcc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hcc_pkg::ORDER_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_action,
  input  logic [hcc_pkg::COORD_W-1:0] in_x_coord,
  input  logic [hcc_pkg::COORD_W-1:0] in_y_coord,
  input  logic [hcc_pkg::INDEX_W-1:0] in_curve_index,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [hcc_pkg::COORD_W-1:0] out_x_out,
  input  logic [hcc_pkg::COORD_W-1:0] out_y_out,
  input  logic [hcc_pkg::INDEX_W-1:0] out_index_out,
  output int                          pending_results,
  output int                          fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] idx;
  } hcc_result_t;

  hcc_result_t        expected_results[$];
  logic [ORDER_W-1:0] order_reg = RESET_ORDER;
  int                 error_count = 0;
  int                 result_count = 0;

  function automatic int unsigned clamp_order(logic [ORDER_W-1:0] v);
    if (v < MIN_ORDER) return int'(MIN_ORDER);
    if (v > MAX_ORDER) return int'(MAX_ORDER);
    return int'(v);
  endfunction

  // Reflects the square of side s when rx is set, then swaps the axes.
  // Nothing happens in the upper half (ry set).
  function automatic void fold_quadrant(input logic [31:0] s, inout logic [31:0] x,
                                        inout logic [31:0] y, input logic rx,
                                        input logic ry);
    logic [31:0] t;
    if (!ry) begin
      if (rx) begin
        x = s - 1 - x;
        y = s - 1 - y;
      end
      t = x;
      x = y;
      y = t;
    end
  endfunction

  function automatic logic [INDEX_W-1:0] cell_to_distance(int unsigned m, logic [31:0] x,
                                                          logic [31:0] y);
    logic [63:0] d;
    logic [31:0] s;
    logic        rx;
    logic        ry;
    d = '0;
    for (int k = int'(m) - 1; k >= 0; k--) begin
      s  = 32'd1 << k;
      rx = x[k];
      ry = y[k];
      d  = d + 64'(s) * 64'(s) * 64'({rx, rx ^ ry});
      x  = x & (s - 1);
      y  = y & (s - 1);
      fold_quadrant(s, x, y, rx, ry);
    end
    return d[INDEX_W-1:0];
  endfunction

  function automatic void distance_to_cell(input int unsigned m, input logic [63:0] d,
                                           output logic [31:0] x, output logic [31:0] y);
    logic [63:0] t;
    logic [31:0] s;
    logic        rx;
    logic        ry;
    x = '0;
    y = '0;
    t = d;
    for (int k = 0; k < int'(m); k++) begin
      s  = 32'd1 << k;
      rx = t[1];
      ry = t[0] ^ rx;
      fold_quadrant(s, x, y, rx, ry);
      x  = x + (rx ? s : 32'd0);
      y  = y + (ry ? s : 32'd0);
      t  = t >> 2;
    end
  endfunction

  function automatic hcc_result_t convert_item(logic [ORDER_W-1:0] order_v, logic act,
                                               logic [COORD_W-1:0] xc,
                                               logic [COORD_W-1:0] yc,
                                               logic [INDEX_W-1:0] dc);
    int unsigned m;
    logic [31:0] cmask;
    logic [63:0] dmask;
    logic [31:0] xo;
    logic [31:0] yo;
    hcc_result_t r;
    m     = clamp_order(order_v);
    cmask = (32'd1 << m) - 1;
    dmask = (64'd1 << (2 * m)) - 1;
    r     = '0;
    if (hcc_action_t'(act) == ACT_TO_INDEX) begin
      r.idx = cell_to_distance(m, 32'(xc) & cmask, 32'(yc) & cmask);
    end else begin
      distance_to_cell(m, 64'(dc) & dmask, xo, yo);
      r.x = xo[COORD_W-1:0];
      r.y = yo[COORD_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hcc_result_t want;
    if (!rst_n) begin
      order_reg = RESET_ORDER;
    end else begin
      // A beat taken at this edge still sees the order from before the edge.
      if (in_valid && !in_stall) begin
        expected_results.push_back(convert_item(order_reg, in_action, in_x_coord,
                                                in_y_coord, in_curve_index));
      end
      if (cfg_wr_en) begin
        order_reg = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          if (error_count < 10) begin
            $display("result %0d: unexpected beat x=%h y=%h index=%h", result_count,
                     out_x_out, out_y_out, out_index_out);
          end
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.x !== out_x_out || want.y !== out_y_out || want.idx !== out_index_out)
          begin
            if (error_count < 10) begin
              $display("result %0d: expected x=%h y=%h index=%h, got x=%h y=%h index=%h",
                       result_count, want.x, want.y, want.idx, out_x_out, out_y_out,
                       out_index_out);
            end
            error_count++;
          end
        end
      end
    end
    pending_results = expected_results.size();
    fail_count      = error_count + expected_results.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;

  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 132;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = ACT_TO_INDEX;
  logic [COORD_W-1:0] in_x_coord = '0;
  logic [COORD_W-1:0] in_y_coord = '0;
  logic [INDEX_W-1:0] in_curve_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_x_out;
  logic [COORD_W-1:0] out_y_out;
  logic [INDEX_W-1:0] out_index_out;

  int pending_results;
  int fail_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int squeeze_reqs = 0;
  int squeezes_done = 0;

  hilbert_curve_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_curve_index (in_curve_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_out      (out_x_out),
    .out_y_out      (out_y_out),
    .out_index_out  (out_index_out)
  );

  hcc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_curve_index  (in_curve_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_out       (out_x_out),
    .out_y_out       (out_y_out),
    .out_index_out   (out_index_out),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offers one beat, with a random gap in front, and returns on the edge that takes it.
  task automatic offer_conversion(logic act, logic [COORD_W-1:0] xc, logic [COORD_W-1:0] yc,
                                  logic [INDEX_W-1:0] dc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_x_coord     <= xc;
    in_y_coord     <= yc;
    in_curve_index <= dc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_conversion(int unsigned m);
    logic [COORD_W-1:0] xc;
    logic [COORD_W-1:0] yc;
    logic [INDEX_W-1:0] dc;
    logic               act;
    act = 1'($urandom_range(0, 1));
    xc  = COORD_W'($urandom);
    yc  = COORD_W'($urandom);
    dc  = $urandom;
    // Most beats stay inside the grid; the rest carry junk in the ignored high bits.
    if ($urandom_range(0, 3) != 0) begin
      xc = xc & COORD_W'((32'd1 << m) - 1);
      yc = yc & COORD_W'((32'd1 << m) - 1);
      dc = dc & INDEX_W'((64'd1 << (2 * m)) - 1);
    end
    offer_conversion(act, xc, yc, dc);
  endtask

  initial begin
    int unsigned        m;
    logic [ORDER_W-1:0] order_list[PHASES];
    order_list = '{5'd1, 5'd0, 5'd16, 5'd17, 5'd31, 5'd2, 5'd7, 5'd0, 5'd0, 5'd11, 5'd15,
                   5'd4};
    order_list[7] = ORDER_W'($urandom_range(1, 16));
    order_list[8] = ORDER_W'($urandom_range(0, 31));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset order, some with the unused fields loaded.
    offer_conversion(ACT_TO_INDEX, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    offer_conversion(ACT_TO_INDEX, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_conversion(ACT_TO_INDEX, 16'hFFFF, 16'h0000, 32'h0000_0000);
    offer_conversion(ACT_TO_INDEX, 16'h0000, 16'hFFFF, 32'h1234_5678);
    offer_conversion(ACT_TO_INDEX, 16'h5555, 16'hAAAA, 32'h0);
    offer_conversion(ACT_TO_INDEX, 16'hAAAA, 16'h5555, 32'h0);
    offer_conversion(ACT_TO_INDEX, 16'h8000, 16'h0001, 32'h0);
    offer_conversion(ACT_TO_INDEX, 16'h0001, 16'h8000, 32'h0);
    offer_conversion(ACT_TO_COORDS, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    offer_conversion(ACT_TO_COORDS, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    offer_conversion(ACT_TO_COORDS, 16'h1234, 16'h4321, 32'h5555_5555);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'hAAAA_AAAA);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'h8000_0000);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'h0000_0001);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'h0000_0002);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'h0000_0003);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'h4000_0000);
    offer_conversion(ACT_TO_COORDS, 16'h0, 16'h0, 32'hC000_0000);
    drain_pipeline();

    for (int p = 0; p < PHASES; p++) begin
      write_order(order_list[p]);
      m = (order_list[p] < MIN_ORDER) ? int'(MIN_ORDER) :
          (order_list[p] > MAX_ORDER) ? int'(MAX_ORDER) : int'(order_list[p]);
      case (p / 4)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 5 || p == 9) squeeze_reqs++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_conversion(m);
      end
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stalls, or one long hold-off so that the pipeline fills.
  initial begin
    @(posedge clk);
    forever begin
      if (squeeze_reqs != squeezes_done) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeezes_done = squeeze_reqs;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
